/* src/nfsa_pkg.sv */
// Shared types and constants of the next-fit slot allocator.
package nfsa_pkg;

  // Field widths of the item and result beats and of the config word
  localparam int unsigned IdxFieldW = 10;
  localparam int unsigned LenFieldW = 10;
  localparam int unsigned TimeW     = 63;
  localparam int unsigned CfgW      = 20;

  // Publication interval after reset, in microseconds
  localparam logic [CfgW-1:0] PubIntervalReset = 20'd10000;

  // Command codes
  localparam logic CmdAlloc   = 1'b0;
  localparam logic CmdRelease = 1'b1;

  typedef enum logic [1:0] {
    STAT_GRANTED  = 2'd0,
    STAT_TOO_LONG = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_RELEASED = 2'd3
  } status_e;

  typedef struct packed {
    logic                 command;
    logic [LenFieldW-1:0] record_length;
    logic [IdxFieldW-1:0] release_index;
    logic [TimeW-1:0]     now_us;
  } nfsa_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [IdxFieldW-1:0] slot_index;
    logic                 publish;
    logic [IdxFieldW-1:0] published_index;
  } nfsa_out_t;

  // Control from the sequencer to the publication unit
  typedef struct packed {
    logic                 prep;    // latch now minus last publication time
    logic                 commit;  // publish index at this edge
    logic [IdxFieldW-1:0] index;
  } pub_ctl_t;

endpackage

/* src/next_fit_slot_allocator.sv */
// Top level of the next-fit slot allocator.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one command per beat:
// allocate a slot for record_length bytes, or release a slot. Every command
// gives exactly one result beat on out_valid_o / out_stall_i / out_data_o.
// The one register, publish_interval, is written on cfg_valid_i / cfg_ready_o
// with cfg_data_i; cfg_ready_o is always high.
// Flow: a release or a rejected allocate reaches the result register in the
// cycle after its accept. An allocate reaches the result register after P
// probes, P being the number of slots probed (1 to NUM_SLOTS-1); each probe
// is one read of the slot length memory, whose registered read port sets the
// pace of one probe a cycle. The next beat is taken only once the result has
// moved on from the result register into the output register.
// Reset: the slot length memory is cleared one entry per cycle, over all
// NUM_SLOTS entries; in_stall_o stays high until that pass is done.
// When the receiver stalls, the result holds in the output register; the next
// item is still accepted and worked, and waits only to hand over its result.
module next_fit_slot_allocator #(
  parameter int unsigned NUM_SLOTS  = 1024,
  parameter int unsigned SLOT_BYTES = 512
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  nfsa_pkg::nfsa_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output nfsa_pkg::nfsa_out_t        out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [nfsa_pkg::CfgW-1:0]  cfg_data_i
);
  import nfsa_pkg::*;

  localparam int unsigned IdxW = $clog2(NUM_SLOTS);
  localparam int unsigned LenW = $clog2(SLOT_BYTES - 1);
  localparam logic [IdxW-1:0] LastEntry = IdxW'(NUM_SLOTS - 1);
  localparam logic [IdxW-1:0] RingLen   = IdxW'(NUM_SLOTS - 1);
  localparam logic [IdxW-1:0] LastTry   = IdxW'(NUM_SLOTS - 2);
  localparam logic [31:0]     NumSlotsW = 32'(NUM_SLOTS);
  localparam logic [31:0]     MaxLen    = 32'(SLOT_BYTES - 2);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_PROBE  = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] clr_q, clr_d;
  logic [IdxW-1:0] cursor_q, cursor_d;
  logic [IdxW-1:0] tries_q, tries_d;
  status_e         res_status_q, res_status_d;
  logic [IdxW-1:0] res_slot_q, res_slot_d;
  nfsa_in_t        item_q;
  logic            out_valid_q, out_valid_d;
  nfsa_out_t       out_q, out_d;

  logic            in_accept;
  logic            can_load;
  logic            rel_in_range;
  logic [IdxW-1:0] probe_slot;
  logic [IdxW-1:0] ring_next;
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  logic [LenW-1:0] wdata, rdata;
  pub_ctl_t        pub_ctl;
  logic            due;
  logic            pub_now;
  logic [IdxFieldW-1:0] header;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign can_load    = !out_valid_q || !out_stall_i;

  assign rel_in_range = (in_data_i.release_index != '0) &&
                        (32'(in_data_i.release_index) < NumSlotsW);

  // Slot under probe and cursor after it
  assign probe_slot = cursor_q + IdxW'(1);
  assign ring_next  = (probe_slot >= RingLen) ? '0 : probe_slot;
  assign raddr      = cursor_d + IdxW'(1);

  // Sequencer: clearing pass, accept, probe loop, result hand-off
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cursor_d     = cursor_q;
    tries_d      = tries_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    we           = 1'b0;
    waddr        = clr_q;
    wdata        = '0;
    pub_ctl      = '0;
    pub_now      = (res_status_q == STAT_GRANTED) && due;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        clr_d = clr_q + IdxW'(1);
        if (clr_q == LastEntry) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          res_slot_d = '0;
          tries_d    = '0;
          if (in_data_i.command == CmdRelease) begin
            res_status_d = STAT_RELEASED;
            we           = rel_in_range;
            waddr        = IdxW'(in_data_i.release_index);
            state_d      = S_RESULT;
          end else if (32'(in_data_i.record_length) > MaxLen) begin
            res_status_d = STAT_TOO_LONG;
            state_d      = S_RESULT;
          end else begin
            state_d = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        pub_ctl.prep = 1'b1;
        cursor_d     = ring_next;
        tries_d      = tries_q + IdxW'(1);
        if (rdata == '0) begin
          we           = 1'b1;
          waddr        = probe_slot;
          wdata        = LenW'(item_q.record_length);
          res_status_d = STAT_GRANTED;
          res_slot_d   = probe_slot;
          state_d      = S_RESULT;
        end else if (tries_q == LastTry) begin
          res_status_d = STAT_FULL;
          state_d      = S_RESULT;
        end
      end
      S_RESULT: begin
        if (can_load) begin
          pub_ctl.commit = pub_now;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    pub_ctl.index = IdxFieldW'(res_slot_q);
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (state_q == S_RESULT && can_load) begin
      out_valid_d               = 1'b1;
      out_d.status              = res_status_q;
      out_d.slot_index          = IdxFieldW'(res_slot_q);
      out_d.publish             = pub_now;
      out_d.published_index     = pub_now ? IdxFieldW'(res_slot_q) : header;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cursor_q    <= '0;
      tries_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cursor_q    <= cursor_d;
      tries_q     <= tries_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    out_q        <= out_d;
  end

  nfsa_ram #(
    .WIDTH (LenW),
    .DEPTH (NUM_SLOTS)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  nfsa_pub u_pub (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .now_i      (item_q.now_us),
    .ctl_i      (pub_ctl),
    .due_o      (due),
    .header_o   (header)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* src/nfsa_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module nfsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/nfsa_pub.sv */
// Publication rate limiter: interval register, last publication time, header index.
module nfsa_pub (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nfsa_pkg::CfgW-1:0]     cfg_data_i,
  input  logic [nfsa_pkg::TimeW-1:0]    now_i,
  input  nfsa_pkg::pub_ctl_t            ctl_i,
  output logic                          due_o,
  output logic [nfsa_pkg::IdxFieldW-1:0] header_o
);
  import nfsa_pkg::*;

  logic [CfgW-1:0]      interval_q;
  logic [TimeW-1:0]     last_q;
  logic [IdxFieldW-1:0] header_q;
  logic [TimeW:0]       diff_q;   // top bit is the borrow
  logic                 never_q;  // last publication time reads as zero

  // Interval, last time and header
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= PubIntervalReset;
      last_q     <= '0;
      header_q   <= '0;
      never_q    <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        interval_q <= cfg_data_i;
      end
      if (ctl_i.commit) begin
        last_q   <= now_i;
        header_q <= ctl_i.index;
        never_q  <= (now_i == '0);
      end
    end
  end

  // Elapsed time, taken while the ring is probed
  always_ff @(posedge clk_i) begin
    if (ctl_i.prep) begin
      diff_q <= {1'b0, now_i} - {1'b0, last_q};
    end
  end

  // Due when the last publication time is zero, or time went forward by at least the interval
  assign due_o    = never_q ||
                    (!diff_q[TimeW] && (diff_q[TimeW-1:0] >= TimeW'(interval_q)));
  assign header_o = header_q;

endmodule

/* src/nfsa_chk.sv */
// Port-level checks of the next-fit slot allocator, bound to the top level.
module nfsa_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input nfsa_pkg::nfsa_out_t out_data_o
);
  import nfsa_pkg::*;

  // An accepted command beat closes the input for at least the next cycle
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open right after an accepted beat");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // Only a grant carries a slot index or a publication
  a_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STAT_GRANTED) |->
      !out_data_o.publish && (out_data_o.slot_index == '0))
    else $error("slot index or publish without grant");

  // The header slot is never granted
  a_no_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STAT_GRANTED) |-> out_data_o.slot_index != '0)
    else $error("header slot granted");

  // A publication puts the granted index in the header
  a_pub_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.publish |->
      out_data_o.published_index == out_data_o.slot_index)
    else $error("published index differs from grant");

endmodule

bind next_fit_slot_allocator nfsa_chk u_nfsa_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
